>>> design/ssvg_pkg.sv
// Shared types, constants and tables for the spiral segment vertex generator.
`timescale 1ns / 1ps
`default_nettype none

package ssvg_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENTS     = 3'd0,
        CFG_TURNS        = 3'd1,
        CFG_MAX_RADIUS   = 3'd2,
        CFG_ORIGIN_COLOR = 3'd3,
        CFG_TIP_COLOR    = 3'd4
    } t_cfg_idx;

    // Register widths
    localparam int SEG_W  = 13;
    localparam int TURN_W = 9;
    localparam int RAD_W  = 15;
    localparam int RGB_W  = 24;
    localparam int CH_W   = 8;
    localparam int N_W    = SEG_W + TURN_W;

    // Register reset values
    localparam logic [SEG_W-1:0]  SEG_RST  = 13'd64;
    localparam logic [TURN_W-1:0] TURN_RST = 9'd4;
    localparam logic [RAD_W-1:0]  RAD_RST  = 15'd16384;
    localparam logic [RGB_W-1:0]  ORG_RST  = 24'h000000;
    localparam logic [RGB_W-1:0]  TIP_RST  = 24'hFFFFFF;

    // Parameter defaults
    localparam int COORD_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF = 20;
    localparam int ANGLE_BITS_DEF = 16;

    // Trig: Q1.15 results, CORDIC in 2^-30 vectors and 2^-32 turn angles
    localparam int TRIG_W       = 16;
    localparam int CORDIC_W     = 32;
    localparam int CORDIC_STEPS = 20;
    localparam int COORD_Q_W    = 15;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032875;

    localparam logic signed [CORDIC_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
        32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
        32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
        32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518
    };

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    // Round a 2^-30 CORDIC component to Q1.15 and clamp to +-32767
    function automatic logic signed [TRIG_W-1:0] trig_round(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [CORDIC_W-1:0] r;
        r = (v + 32'sd16384) >>> 15;
        if (r > 32'sd32767) begin
            r = 32'sd32767;
        end else if (r < -32'sd32767) begin
            r = -32'sd32767;
        end
        return TRIG_W'(r);
    endfunction

endpackage

`default_nettype wire

>>> design/ssvg_seg_if.sv
// Input channel: segment index with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface ssvg_seg_if import ssvg_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] segment_index;

    modport source (output valid, output segment_index, input ready);
    modport sink   (input valid, input segment_index, output ready);
endinterface

`default_nettype wire

>>> design/ssvg_res_if.sv
// Result channel: segment endpoints and colors with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface ssvg_res_if import ssvg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         valid_res;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [RGB_W-1:0]             start_rgb;
    logic [RGB_W-1:0]             end_rgb;

    modport source (output valid, output valid_res, output start_x, output start_y,
                    output end_x, output end_y, output start_rgb, output end_rgb,
                    input ready);
    modport sink   (input valid, input valid_res, input start_x, input start_y,
                    input end_x, input end_y, input start_rgb, input end_rgb,
                    output ready);
endinterface

`default_nettype wire

>>> design/spiral_segment_vertex_generator.sv
// Spiral segment vertex generator: top level with config registers and the main pipeline.
// Stages from input transfer to result, in order: color divide, modulo, angle divide,
//   CORDIC, trig round, multiply, coordinate divide, output register.
// Throughput: one segment per cycle; a stalled result freezes the whole pipeline.
// Synchronous active-low reset empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module spiral_segment_vertex_generator import ssvg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ssvg_seg_if.sink              i_seg,
    ssvg_res_if.source            o_res
);

    localparam int K_W    = INDEX_BITS + 1;
    localparam int CNUM_W = CH_W + K_W + 1;
    localparam int ANUM_W = SEG_W + ANGLE_BITS;
    localparam int PROD_W = RAD_W + TRIG_W - 1;
    localparam int KNUM_W = PROD_W + K_W + 1;
    localparam int KDEN_W = N_W + COORD_Q_W;
    localparam int LIM    = 2 ** (COORD_BITS - 1) - 1;
    localparam int LAST   = CORDIC_STEPS - 1;

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic                  ok;
    } t_head;

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic                  ok;
        logic [RGB_W-1:0]      rgb0;
        logic [RGB_W-1:0]      rgb1;
    } t_meta;

    typedef struct packed {
        t_meta      meta;
        logic [3:0] neg;
    } t_cmeta;

    // Configuration registers; the total segment count is updated with the write
    logic [SEG_W-1:0]  r_seg;
    logic [TURN_W-1:0] r_turns;
    logic [RAD_W-1:0]  r_rad;
    logic [RGB_W-1:0]  r_org;
    logic [RGB_W-1:0]  r_tip;
    logic [N_W-1:0]    r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg   <= SEG_RST;
            r_turns <= TURN_RST;
            r_rad   <= RAD_RST;
            r_org   <= ORG_RST;
            r_tip   <= TIP_RST;
            r_n     <= N_W'(SEG_RST) * N_W'(TURN_RST);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SEGMENTS: begin
                    r_seg <= i_cfg_data[SEG_W-1:0];
                    r_n   <= N_W'(i_cfg_data[SEG_W-1:0]) * N_W'(r_turns);
                end
                CFG_TURNS: begin
                    r_turns <= i_cfg_data[TURN_W-1:0];
                    r_n     <= N_W'(r_seg) * N_W'(i_cfg_data[TURN_W-1:0]);
                end
                CFG_MAX_RADIUS:   r_rad   <= i_cfg_data[RAD_W-1:0];
                CFG_ORIGIN_COLOR: r_org   <= i_cfg_data[RGB_W-1:0];
                CFG_TIP_COLOR:    r_tip   <= i_cfg_data[RGB_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: pipeline moves unless the output holds an untaken result
    logic r_out_vld;
    logic w_adv;

    assign w_adv       = !r_out_vld || o_res.ready;
    assign i_seg.ready = w_adv;

    // Color divide inputs: |tip - origin| * k (+ N-1 for ceiling when falling)
    logic [5:0][CNUM_W-1:0] w_cnum;
    t_head                  w_head;

    always_comb begin
        logic [K_W-1:0]  k;
        logic [CH_W-1:0] o;
        logic [CH_W-1:0] t;
        logic            neg;
        logic [CH_W-1:0] mag;
        w_head.idx = i_seg.segment_index;
        w_head.ok  = 32'(i_seg.segment_index) < 32'(r_n);
        for (int e = 0; e < 2; e++) begin
            for (int ch = 0; ch < 3; ch++) begin
                k   = K_W'(i_seg.segment_index) + K_W'(e);
                o   = r_org[ch*CH_W +: CH_W];
                t   = r_tip[ch*CH_W +: CH_W];
                neg = t < o;
                mag = neg ? o - t : t - o;
                w_cnum[e*3+ch] = CNUM_W'(mag) * CNUM_W'(k)
                               + (neg ? CNUM_W'(r_n - 1'b1) : '0);
            end
        end
    end

    logic                 w_col_vld;
    logic [5:0][CH_W-1:0] w_col_q;
    t_head                w_col_head;

    ssvg_div_pipe #(
        .LANES  (6),
        .NUM_W  (CNUM_W),
        .DEN_W  (N_W),
        .Q_W    (CH_W),
        .SIDE_W ($bits(t_head))
    ) u_col_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (i_seg.valid),
        .i_num   (w_cnum),
        .i_den   (r_n),
        .i_side  (w_head),
        .o_vld   (w_col_vld),
        .o_quo   (w_col_q),
        .o_rem   (),
        .o_side  (w_col_head)
    );

    // Apply color offsets
    t_meta w_col_meta;

    always_comb begin
        logic [CH_W-1:0]  o;
        logic [CH_W-1:0]  t;
        logic [RGB_W-1:0] rgb [2];
        for (int e = 0; e < 2; e++) begin
            for (int ch = 0; ch < 3; ch++) begin
                o = r_org[ch*CH_W +: CH_W];
                t = r_tip[ch*CH_W +: CH_W];
                rgb[e][ch*CH_W +: CH_W] = (t < o) ? o - w_col_q[e*3+ch]
                                                  : o + w_col_q[e*3+ch];
            end
        end
        w_col_meta.idx  = w_col_head.idx;
        w_col_meta.ok   = w_col_head.ok;
        w_col_meta.rgb0 = rgb[0];
        w_col_meta.rgb1 = rgb[1];
    end

    // Position within the turn: index mod segments_per_turn
    logic                        w_mod_vld;
    logic [0:0][INDEX_BITS-1:0]  w_mod_num;
    logic [0:0][SEG_W-1:0]       w_mod_rem;
    t_meta                       w_mod_meta;

    assign w_mod_num[0] = w_col_meta.idx;

    ssvg_div_pipe #(
        .LANES  (1),
        .NUM_W  (INDEX_BITS),
        .DEN_W  (SEG_W),
        .Q_W    (INDEX_BITS),
        .SIDE_W ($bits(t_meta))
    ) u_mod_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_col_vld),
        .i_num   (w_mod_num),
        .i_den   (r_seg),
        .i_side  (w_col_meta),
        .o_vld   (w_mod_vld),
        .o_quo   (),
        .o_rem   (w_mod_rem),
        .o_side  (w_mod_meta)
    );

    // Angle divide inputs: (r << ANGLE_BITS) + S/2, for this and the next position
    logic [1:0][ANUM_W-1:0] w_anum;

    always_comb begin
        logic [SEG_W:0]   r1w;
        logic [SEG_W-1:0] r1;
        r1w = {1'b0, w_mod_rem[0]} + 1'b1;
        r1  = (r1w == {1'b0, r_seg}) ? '0 : r1w[SEG_W-1:0];
        w_anum[0] = (ANUM_W'(w_mod_rem[0]) << ANGLE_BITS) + ANUM_W'(r_seg >> 1);
        w_anum[1] = (ANUM_W'(r1) << ANGLE_BITS) + ANUM_W'(r_seg >> 1);
    end

    logic                       w_ang_vld;
    logic [1:0][ANGLE_BITS-1:0] w_ang;
    t_meta                      w_ang_meta;

    ssvg_div_pipe #(
        .LANES  (2),
        .NUM_W  (ANUM_W),
        .DEN_W  (SEG_W),
        .Q_W    (ANGLE_BITS),
        .SIDE_W ($bits(t_meta))
    ) u_ang_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_mod_vld),
        .i_num   (w_anum),
        .i_den   (r_seg),
        .i_side  (w_mod_meta),
        .o_vld   (w_ang_vld),
        .o_quo   (w_ang),
        .o_rem   (),
        .o_side  (w_ang_meta)
    );

    // CORDIC rotation, one micro-rotation per stage, two angles side by side
    logic signed [CORDIC_W-1:0] r_cx [CORDIC_STEPS][2];
    logic signed [CORDIC_W-1:0] r_cy [CORDIC_STEPS][2];
    logic signed [CORDIC_W-1:0] r_cz [CORDIC_STEPS][2];
    logic [1:0]                 r_cq [CORDIC_STEPS][2];
    logic                       r_cv [CORDIC_STEPS];
    t_meta                      r_cm [CORDIC_STEPS];

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
        logic signed [CORDIC_W-1:0] p_x [2];
        logic signed [CORDIC_W-1:0] p_y [2];
        logic signed [CORDIC_W-1:0] p_z [2];
        logic [1:0]                 p_q [2];
        logic                       p_v;
        t_meta                      p_m;
        logic signed [CORDIC_W-1:0] n_x [2];
        logic signed [CORDIC_W-1:0] n_y [2];
        logic signed [CORDIC_W-1:0] n_z [2];

        if (s == 0) begin : g_init
            // Widen to 32 bits of a turn; top two bits pick the quadrant
            always_comb begin
                logic [CORDIC_W-1:0] t;
                for (int l = 0; l < 2; l++) begin
                    t      = CORDIC_W'(w_ang[l]) << (CORDIC_W - ANGLE_BITS);
                    p_q[l] = t[CORDIC_W-1 -: 2];
                    p_z[l] = signed'({2'b00, t[CORDIC_W-3:0]});
                    p_x[l] = CORDIC_X0;
                    p_y[l] = '0;
                end
                p_v = w_ang_vld;
                p_m = w_ang_meta;
            end
        end else begin : g_chain
            always_comb begin
                p_x = r_cx[s-1];
                p_y = r_cy[s-1];
                p_z = r_cz[s-1];
                p_q = r_cq[s-1];
                p_v = r_cv[s-1];
                p_m = r_cm[s-1];
            end
        end

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                if (!p_z[l][CORDIC_W-1]) begin
                    n_x[l] = p_x[l] - (p_y[l] >>> s);
                    n_y[l] = p_y[l] + (p_x[l] >>> s);
                    n_z[l] = p_z[l] - CORDIC_ATAN[s];
                end else begin
                    n_x[l] = p_x[l] + (p_y[l] >>> s);
                    n_y[l] = p_y[l] - (p_x[l] >>> s);
                    n_z[l] = p_z[l] + CORDIC_ATAN[s];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[s] <= 1'b0;
            end else if (w_adv) begin
                r_cv[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_cx[s] <= n_x;
                r_cy[s] <= n_y;
                r_cz[s] <= n_z;
                r_cq[s] <= p_q;
                r_cm[s] <= p_m;
            end
        end
    end

    // Round to Q1.15 and unfold quadrant: lanes c0, s0, c1, s1
    logic signed [TRIG_W-1:0] w_trig [4];
    logic signed [TRIG_W-1:0] r_trig [4];
    logic                     r_tv;
    t_meta                    r_tm;

    always_comb begin
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] sn;
        for (int l = 0; l < 2; l++) begin
            c  = trig_round(r_cx[LAST][l]);
            sn = trig_round(r_cy[LAST][l]);
            case (t_quad'(r_cq[LAST][l]))
                QUAD_I: begin
                    w_trig[2*l]   = c;
                    w_trig[2*l+1] = sn;
                end
                QUAD_II: begin
                    w_trig[2*l]   = -sn;
                    w_trig[2*l+1] = c;
                end
                QUAD_III: begin
                    w_trig[2*l]   = -c;
                    w_trig[2*l+1] = -sn;
                end
                default: begin
                    w_trig[2*l]   = sn;
                    w_trig[2*l+1] = -c;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else if (w_adv) begin
            r_tv <= r_cv[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_trig <= w_trig;
            r_tm   <= r_cm[LAST];
        end
    end

    // Multiply 1: max_radius * |trig|
    logic [PROD_W-1:0] r_p    [4];
    logic [3:0]        r_pneg;
    logic              r_pv;
    t_meta             r_pm;
    logic [PROD_W-1:0] w_p    [4];
    logic [3:0]        w_pneg;

    always_comb begin
        logic [TRIG_W-1:0] a;
        for (int l = 0; l < 4; l++) begin
            w_pneg[l] = r_trig[l] < 0;
            a         = w_pneg[l] ? TRIG_W'(-r_trig[l]) : TRIG_W'(r_trig[l]);
            w_p[l]    = PROD_W'(r_rad) * PROD_W'(a[TRIG_W-2:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_adv) begin
            r_pv <= r_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p    <= w_p;
            r_pneg <= w_pneg;
            r_pm   <= r_tm;
        end
    end

    // Multiply 2: times k, plus half the divisor for rounding
    logic [3:0][KNUM_W-1:0] r_knum;
    t_cmeta                 r_km;
    logic                   r_kv;
    logic [3:0][KNUM_W-1:0] w_knum;

    always_comb begin
        logic [K_W-1:0] k;
        for (int l = 0; l < 4; l++) begin
            k = K_W'(r_pm.idx) + K_W'(l >= 2);
            w_knum[l] = KNUM_W'(r_p[l]) * KNUM_W'(k)
                      + (KNUM_W'(r_n) << (COORD_Q_W - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv <= 1'b0;
        end else if (w_adv) begin
            r_kv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_knum      <= w_knum;
            r_km.meta   <= r_pm;
            r_km.neg    <= r_pneg;
        end
    end

    // Coordinate divide by N << 15
    logic                        w_crd_vld;
    logic [3:0][COORD_Q_W-1:0]   w_crd_q;
    t_cmeta                      w_crd_meta;
    logic [KDEN_W-1:0]           w_kden;

    assign w_kden = KDEN_W'(r_n) << COORD_Q_W;

    ssvg_div_pipe #(
        .LANES  (4),
        .NUM_W  (KNUM_W),
        .DEN_W  (KDEN_W),
        .Q_W    (COORD_Q_W),
        .SIDE_W ($bits(t_cmeta))
    ) u_crd_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_kv),
        .i_num   (r_knum),
        .i_den   (w_kden),
        .i_side  (r_km),
        .o_vld   (w_crd_vld),
        .o_quo   (w_crd_q),
        .o_rem   (),
        .o_side  (w_crd_meta)
    );

    // Clamp, restore sign, blank invalid segments
    logic [3:0][COORD_BITS-1:0] w_crd;
    logic [3:0][COORD_BITS-1:0] r_out_crd;
    logic                       r_out_ok;
    logic [RGB_W-1:0]           r_out_rgb0;
    logic [RGB_W-1:0]           r_out_rgb1;

    always_comb begin
        logic [COORD_BITS-1:0] m;
        for (int l = 0; l < 4; l++) begin
            m = (int'(w_crd_q[l]) > LIM) ? COORD_BITS'(LIM) : COORD_BITS'(w_crd_q[l]);
            if (!w_crd_meta.meta.ok) begin
                w_crd[l] = '0;
            end else begin
                w_crd[l] = w_crd_meta.neg[l] ? -m : m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_crd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_ok   <= w_crd_meta.meta.ok;
            r_out_crd  <= w_crd;
            r_out_rgb0 <= w_crd_meta.meta.ok ? w_crd_meta.meta.rgb0 : '0;
            r_out_rgb1 <= w_crd_meta.meta.ok ? w_crd_meta.meta.rgb1 : '0;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.valid_res = r_out_ok;
    assign o_res.start_x   = r_out_crd[0];
    assign o_res.start_y   = r_out_crd[1];
    assign o_res.end_x     = r_out_crd[2];
    assign o_res.end_y     = r_out_crd[3];
    assign o_res.start_rgb = r_out_rgb0;
    assign o_res.end_rgb   = r_out_rgb1;

    // Out-of-range segments come out blank
    a_blank_invalid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.valid_res |->
            o_res.start_x == 0 && o_res.start_y == 0 && o_res.end_x == 0 &&
            o_res.end_y == 0 && o_res.start_rgb == 0 && o_res.end_rgb == 0)
        else $error("invalid segment carries nonzero payload");

    // Zero radius collapses every point onto the origin
    a_zero_radius : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.valid_res && r_rad == 0 |->
            o_res.start_x == 0 && o_res.start_y == 0 &&
            o_res.end_x == 0 && o_res.end_y == 0)
        else $error("nonzero coordinate at zero radius");

    // Input is held off only while a finished result waits
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_seg.ready |-> o_res.valid && !o_res.ready)
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire

>>> design/ssvg_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, several lanes, shared divisor.
`timescale 1ns / 1ps
`default_nettype none

module ssvg_div_pipe #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int Q_W    = 8,
    parameter int SIDE_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [LANES-1:0][NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]             i_den,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_vld,
    output logic [LANES-1:0][Q_W-1:0]    o_quo,
    output logic [LANES-1:0][DEN_W-1:0]  o_rem,
    output logic [SIDE_W-1:0]            o_side
);

    // Caller guarantees i_num < (i_den << Q_W), so the partial remainder fits DEN_W bits.
    logic                        r_vld  [Q_W];
    logic [DEN_W-1:0]            r_den  [Q_W];
    logic [SIDE_W-1:0]           r_side [Q_W];
    logic [LANES-1:0][DEN_W-1:0] r_pr   [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_ql   [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic                        p_vld;
        logic [DEN_W-1:0]            p_den;
        logic [SIDE_W-1:0]           p_side;
        logic [LANES-1:0][DEN_W-1:0] p_pr;
        logic [LANES-1:0][Q_W-1:0]   p_ql;
        logic [LANES-1:0][DEN_W:0]   w_t;
        logic [LANES-1:0][DEN_W-1:0] n_pr;
        logic [LANES-1:0][Q_W-1:0]   n_ql;

        // Stage input: ports or previous stage
        if (s == 0) begin : g_first
            always_comb begin
                p_vld  = i_vld;
                p_den  = i_den;
                p_side = i_side;
                for (int l = 0; l < LANES; l++) begin
                    p_pr[l] = DEN_W'(i_num[l] >> Q_W);
                    p_ql[l] = Q_W'(i_num[l]);
                end
            end
        end else begin : g_next
            always_comb begin
                p_vld  = r_vld[s-1];
                p_den  = r_den[s-1];
                p_side = r_side[s-1];
                p_pr   = r_pr[s-1];
                p_ql   = r_ql[s-1];
            end
        end

        // Shift in one dividend bit, trial subtract, shift out one quotient bit
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_t[l] = {p_pr[l], p_ql[l][Q_W-1]};
                if (w_t[l] >= {1'b0, p_den}) begin
                    n_pr[l] = DEN_W'(w_t[l] - {1'b0, p_den});
                    n_ql[l] = (p_ql[l] << 1) | Q_W'(1);
                end else begin
                    n_pr[l] = w_t[l][DEN_W-1:0];
                    n_ql[l] = p_ql[l] << 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s]  <= p_den;
                r_side[s] <= p_side;
                r_pr[s]   <= n_pr;
                r_ql[s]   <= n_ql;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_quo  = r_ql[Q_W-1];
    assign o_rem  = r_pr[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

`default_nettype wire
